@@ sv/bbp_pkg.sv @@
package bbp_pkg;

   // Counter and operand widths
   localparam int CNT_W   = 21;
   localparam int SKIP_W  = 16;
   localparam int N_W     = CNT_W + 1;    // ones_seen + zeros_seen
   localparam int D_W     = CNT_W + 1;    // remaining zeros + 1
   localparam int SUM_W   = D_W + 1;      // modular sums before reduction

   localparam int MUL_STEPS = N_W;        // one multiplier bit per step
   localparam int STEP_W    = $clog2(MUL_STEPS);

   localparam int CHUNK_BITS    = 1048576;
   localparam int CNT_MAX_INT   = (2 ** CNT_W) - 1;
   localparam int POS_LIMIT_INT = (CHUNK_BITS < CNT_MAX_INT) ? CHUNK_BITS : CNT_MAX_INT;

   localparam logic [CNT_W-1:0] POS_LIMIT = CNT_W'(POS_LIMIT_INT);
   localparam logic [CNT_W-1:0] CNT_MAX   = CNT_W'(CNT_MAX_INT);

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = CNT_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ONES_TOTAL    = 2'd0,
      CSR_ZEROS_TOTAL   = 2'd1,
      CSR_INITIAL_SKIPS = 2'd2,
      CSR_SKIP_COUNT    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_PREP,
      ST_MUL,
      ST_FIN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load_item;
      logic eval;
      logic prep;
      logic mul_step;
      logic finish;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic drop;
      logic pass;
      logic early;
      logic mul_last;
      logic out_free;
   } sts_type;

endpackage

@@ sv/bbp_ctrl.sv @@
module bbp_ctrl
   import bbp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (sts.drop) begin
               state_in = ST_IDLE;
            end else if (sts.pass) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = sts.early ? ST_EMIT : ST_MUL;
         end
         ST_MUL: begin
            if (sts.mul_last) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
         end
         ST_FIN: begin
            cmd.finish = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

@@ sv/bbp_dp.sv @@
module bbp_dp
   import bbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_data_bit,
   input  logic                  req_chunk_start,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_out_bit,
   output logic                  rsp_was_processed,
   input  cmd_type               cmd,
   output sts_type               sts
);

   // configuration
   logic [CNT_W-1:0]  ones_total_ff, ones_total_in;
   logic [CNT_W-1:0]  zeros_total_ff, zeros_total_in;
   logic [CNT_W-1:0]  init_skips_ff, init_skips_in;
   logic [SKIP_W-1:0] skip_count_ff, skip_count_in;

   // chunk state
   logic [CNT_W-1:0]  ones_seen_ff, ones_seen_in;
   logic [CNT_W-1:0]  zeros_seen_ff, zeros_seen_in;
   logic              phase_ff, phase_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [SKIP_W-1:0] kp_ff, kp_in;

   // current transaction and guess evaluation
   logic              bit_ff, bit_in;
   logic              start_ff, start_in;
   logic              proc_ff, proc_in;
   logic [CNT_W-1:0]  r1_ff, r1_in;
   logic [D_W-1:0]    d_ff, d_in;
   logic [N_W-1:0]    m_ff, m_in;
   logic [D_W-1:0]    acc_ff, acc_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              eq_ff, eq_in;

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_bit_ff, rsp_bit_in;
   logic              rsp_proc_ff, rsp_proc_in;

   // chunk_start clears the state before the bit is handled
   logic [CNT_W-1:0]  pos_eff;
   logic [SKIP_W-1:0] kp_eff;

   logic [CNT_W-1:0]  r1_c, r0_c;
   logic [D_W-1:0]    d_c;
   logic [N_W-1:0]    n_c;
   logic              r1_lt_d;

   logic [SUM_W-1:0]  t1, t1r, t2, t2r, fin_sum;
   logic              guess;

   assign pos_eff = start_ff ? '0 : pos_ff;
   assign kp_eff  = start_ff ? '0 : kp_ff;

   assign r1_c    = (ones_total_ff > ones_seen_ff) ? (ones_total_ff - ones_seen_ff) : '0;
   assign r0_c    = (zeros_total_ff > zeros_seen_ff) ? (zeros_total_ff - zeros_seen_ff) : '0;
   assign d_c     = {1'b0, r0_c} + D_W'(1);
   assign n_c     = {1'b0, ones_seen_ff} + {1'b0, zeros_seen_ff};
   assign r1_lt_d = {1'b0, r1_c} < d_c;

   // one Horner step of ((n-1) * r1) mod d, with r1 < d
   assign t1  = {acc_ff, 1'b0};
   assign t1r = (t1 >= {1'b0, d_ff}) ? (t1 - {1'b0, d_ff}) : t1;
   assign t2  = t1r + (m_ff[N_W-1] ? SUM_W'(r1_ff) : '0);
   assign t2r = (t2 >= {1'b0, d_ff}) ? (t2 - {1'b0, d_ff}) : t2;

   assign fin_sum = {1'b0, acc_ff} + SUM_W'(r1_ff);
   assign guess   = eq_ff | phase_ff;

   assign sts.drop     = pos_eff < init_skips_ff;
   assign sts.pass     = kp_eff != '0;
   assign sts.early    = (n_c == '0) || !r1_lt_d;
   assign sts.mul_last = step_ff == STEP_W'(MUL_STEPS - 1);
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      ones_total_in  = ones_total_ff;
      zeros_total_in = zeros_total_ff;
      init_skips_in  = init_skips_ff;
      skip_count_in  = skip_count_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_ONES_TOTAL:    ones_total_in  = csr_wdata;
            CSR_ZEROS_TOTAL:   zeros_total_in = csr_wdata;
            CSR_INITIAL_SKIPS: init_skips_in  = csr_wdata;
            CSR_SKIP_COUNT:    skip_count_in  = csr_wdata[SKIP_W-1:0];
            default: begin
               ones_total_in = ones_total_ff;
            end
         endcase
      end
   end

   always_comb begin
      bit_in        = bit_ff;
      start_in      = start_ff;
      ones_seen_in  = ones_seen_ff;
      zeros_seen_in = zeros_seen_ff;
      phase_in      = phase_ff;
      pos_in        = pos_ff;
      kp_in         = kp_ff;
      proc_in       = proc_ff;
      r1_in         = r1_ff;
      d_in          = d_ff;
      m_in          = m_ff;
      acc_in        = acc_ff;
      step_in       = step_ff;
      eq_in         = eq_ff;
      rsp_bit_in    = rsp_bit_ff;
      rsp_proc_in   = rsp_proc_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.load_item) begin
         bit_in   = req_data_bit;
         start_in = req_chunk_start;
      end

      if (cmd.eval) begin
         if (start_ff) begin
            ones_seen_in  = '0;
            zeros_seen_in = '0;
            phase_in      = 1'b0;
         end
         pos_in = (pos_eff < POS_LIMIT) ? (pos_eff + CNT_W'(1)) : POS_LIMIT;
         if (sts.drop) begin
            kp_in = kp_eff;
         end else begin
            kp_in = (kp_eff >= skip_count_ff) ? '0 : (kp_eff + SKIP_W'(1));
         end
         proc_in = !sts.pass;
      end

      if (cmd.prep) begin
         r1_in   = r1_c;
         d_in    = d_c;
         m_in    = n_c - N_W'(1);
         acc_in  = '0;
         step_in = '0;
         eq_in   = (n_c == '0) && r1_lt_d;
      end

      if (cmd.mul_step) begin
         acc_in  = t2r[D_W-1:0];
         m_in    = {m_ff[N_W-2:0], 1'b0};
         step_in = step_ff + STEP_W'(1);
      end

      // floor quotients match when the remainder plus r1 stays below d
      if (cmd.finish) begin
         eq_in = fin_sum < {1'b0, d_ff};
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (proc_ff) begin
            rsp_bit_in  = bit_ff ~^ guess;
            rsp_proc_in = 1'b1;
            if (!eq_ff) begin
               phase_in = ~phase_ff;
            end
            if (bit_ff) begin
               ones_seen_in = (ones_seen_ff < CNT_MAX) ? (ones_seen_ff + CNT_W'(1)) : CNT_MAX;
            end else begin
               zeros_seen_in = (zeros_seen_ff < CNT_MAX) ? (zeros_seen_ff + CNT_W'(1)) : CNT_MAX;
            end
         end else begin
            rsp_bit_in  = bit_ff;
            rsp_proc_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ones_total_ff  <= '0;
         zeros_total_ff <= '0;
         init_skips_ff  <= '0;
         skip_count_ff  <= '0;
         ones_seen_ff   <= '0;
         zeros_seen_ff  <= '0;
         phase_ff       <= 1'b0;
         pos_ff         <= '0;
         kp_ff          <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ones_total_ff  <= ones_total_in;
         zeros_total_ff <= zeros_total_in;
         init_skips_ff  <= init_skips_in;
         skip_count_ff  <= skip_count_in;
         ones_seen_ff   <= ones_seen_in;
         zeros_seen_ff  <= zeros_seen_in;
         phase_ff       <= phase_in;
         pos_ff         <= pos_in;
         kp_ff          <= kp_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      bit_ff      <= bit_in;
      start_ff    <= start_in;
      proc_ff     <= proc_in;
      r1_ff       <= r1_in;
      d_ff        <= d_in;
      m_ff        <= m_in;
      acc_ff      <= acc_in;
      step_ff     <= step_in;
      eq_ff       <= eq_in;
      rsp_bit_ff  <= rsp_bit_in;
      rsp_proc_ff <= rsp_proc_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_bit       = rsp_bit_ff;
   assign rsp_was_processed = rsp_proc_ff;

endmodule

@@ sv/bit_balance_predictor_unit.sv @@
// Path to rsp_valid after acceptance: a pass-through bit goes EVAL, EMIT; a processed bit goes
// EVAL, PREP, EMIT when compare alone settles the guess, else EVAL, PREP, MUL, FIN, EMIT;
// a dropped bit has no result. One transaction at a time: the next is accepted in ST_IDLE,
// entered as the result is registered; the 22-step modular multiply sets the rate for
// processed bits, and the result register lets it in while a result waits.
// Reset (synchronous, active high) clears the registers, counters and pattern.
module bit_balance_predictor_unit
   import bbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_data_bit,
   input  logic                  req_chunk_start,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_out_bit,
   output logic                  rsp_was_processed
);

   cmd_type cmd;
   sts_type sts;

   bbp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bbp_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_data_bit      (req_data_bit),
      .req_chunk_start   (req_chunk_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_bit       (rsp_out_bit),
      .rsp_was_processed (rsp_was_processed),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule

@@ tb/bit_balance_checker.sv @@
`timescale 1ns / 1ps
module bit_balance_checker
   import bbp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_data_bit,
   input  logic                  req_chunk_start,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic                  rsp_out_bit,
   input  logic                  rsp_was_processed,
   output int                    outstanding,
   output int                    fail_count
);

   typedef struct packed {
      logic out_bit;
      logic was_processed;
   } balanced_bit_type;

   balanced_bit_type expected_bits[$];

   // register copies
   logic [CNT_W-1:0]  ones_goal, zeros_goal, lead_drop;
   logic [SKIP_W-1:0] period_gap;

   // chunk state
   logic [CNT_W-1:0]  ones_cnt, zeros_cnt, chunk_pos;
   logic [SKIP_W-1:0] period_pos;
   logic              flip;

   int error_tally = 0;

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t ns: %s", $time, what);
      error_tally++;
   endtask

   task automatic predict_bit(input logic data_bit, input logic chunk_start);
      logic   dropped;
      logic   guess;
      longint n, r1, r0, lo, hi;
      if (chunk_start) begin
         ones_cnt   = '0;
         zeros_cnt  = '0;
         flip       = 1'b0;
         chunk_pos  = '0;
         period_pos = '0;
      end
      dropped = chunk_pos < lead_drop;
      if (chunk_pos < POS_LIMIT) begin
         chunk_pos = chunk_pos + 1'b1;
      end
      if (dropped) begin
         return;
      end
      if (period_pos == '0) begin
         n  = longint'(ones_cnt) + longint'(zeros_cnt);
         r1 = (ones_goal > ones_cnt) ? longint'(ones_goal - ones_cnt) : 64'sd0;
         r0 = (zeros_goal > zeros_cnt) ? longint'(zeros_goal - zeros_cnt) : 64'sd0;
         // signed division, truncates toward zero (n-1 is -1 on the first bit)
         lo = ((n - 1) * r1) / (r0 + 1);
         hi = (n * r1) / (r0 + 1);
         if (lo == hi) begin
            guess = 1'b1;
         end else begin
            guess = flip;
            flip  = ~flip;
         end
         expected_bits.push_back(balanced_bit_type'{out_bit: (data_bit == guess),
                                                    was_processed: 1'b1});
         if (data_bit) begin
            if (ones_cnt < CNT_MAX) ones_cnt = ones_cnt + 1'b1;
         end else begin
            if (zeros_cnt < CNT_MAX) zeros_cnt = zeros_cnt + 1'b1;
         end
      end else begin
         expected_bits.push_back(balanced_bit_type'{out_bit: data_bit, was_processed: 1'b0});
      end
      // wrap also when the period was shrunk below the current phase
      if (period_pos >= period_gap) begin
         period_pos = '0;
      end else begin
         period_pos = period_pos + 1'b1;
      end
   endtask

   always @(posedge clock) begin
      balanced_bit_type seen;
      balanced_bit_type want;
      if (reset) begin
         ones_goal  = '0;
         zeros_goal = '0;
         lead_drop  = '0;
         period_gap = '0;
         ones_cnt   = '0;
         zeros_cnt  = '0;
         chunk_pos  = '0;
         period_pos = '0;
         flip       = 1'b0;
         expected_bits.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_ONES_TOTAL:    ones_goal  = csr_wdata[CNT_W-1:0];
               CSR_ZEROS_TOTAL:   zeros_goal = csr_wdata[CNT_W-1:0];
               CSR_INITIAL_SKIPS: lead_drop  = csr_wdata[CNT_W-1:0];
               CSR_SKIP_COUNT:    period_gap = csr_wdata[SKIP_W-1:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            seen = balanced_bit_type'{out_bit: rsp_out_bit, was_processed: rsp_was_processed};
            if (expected_bits.size() == 0) begin
               report_mismatch("result transaction with nothing pending");
            end else begin
               want = expected_bits.pop_front();
               if (seen.out_bit !== want.out_bit) begin
                  report_mismatch($sformatf("out_bit %b, predicted %b",
                                            seen.out_bit, want.out_bit));
               end
               if (seen.was_processed !== want.was_processed) begin
                  report_mismatch($sformatf("was_processed %b, predicted %b",
                                            seen.was_processed, want.was_processed));
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_bit(req_data_bit, req_chunk_start);
         end
      end
      outstanding <= expected_bits.size();
      fail_count  <= error_tally;
   end

endmodule

@@ tb/tb_bit_balance_predictor_unit.sv @@
`timescale 1ns / 1ps
module tb_bit_balance_predictor_unit;
   import bbp_pkg::*;

   localparam int                 ITEMS      = 1780;
   localparam logic [CNT_W-1:0]   TOTAL_TOP  = CNT_W'(1048576);
   localparam logic [SKIP_W-1:0]  GAP_TOP    = 16'hFFFF;

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  csr_we          = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index       = CSR_ONES_TOTAL;
   logic [CSR_DATA_W-1:0] csr_wdata       = '0;
   logic                  req_valid       = 1'b0;
   logic                  req_data_bit    = 1'b0;
   logic                  req_chunk_start = 1'b0;
   logic                  rsp_ready       = 1'b0;
   logic                  req_ready;
   logic                  rsp_valid;
   logic                  rsp_out_bit;
   logic                  rsp_was_processed;

   int outstanding;
   int fail_count;
   int send_idle_pct = 28;
   int recv_idle_pct = 53;

   always #5 clock = ~clock;

   bit_balance_predictor_unit uut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_bit      (req_data_bit),
      .req_chunk_start   (req_chunk_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_bit       (rsp_out_bit),
      .rsp_was_processed (rsp_was_processed)
   );

   bit_balance_checker balance_check (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_bit      (req_data_bit),
      .req_chunk_start   (req_chunk_start),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_bit       (rsp_out_bit),
      .rsp_was_processed (rsp_was_processed),
      .outstanding       (outstanding),
      .fail_count        (fail_count)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= recv_idle_pct;
      end
   end

   task automatic send_bit(input logic data_bit, input logic chunk_start);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_data_bit    <= data_bit;
      req_chunk_start <= chunk_start;
      do @(posedge clock); while (!req_ready);
   endtask

   // hold off until every pending result is back, then let a dropped bit finish
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic put_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic configure(input logic [CNT_W-1:0] ones, input logic [CNT_W-1:0] zeros,
                            input logic [CNT_W-1:0] lead, input logic [SKIP_W-1:0] gap,
                            input logic [3:0] pick);
      settle();
      if (pick[0]) put_reg(CSR_ONES_TOTAL, ones);
      if (pick[1]) put_reg(CSR_ZEROS_TOTAL, zeros);
      if (pick[2]) put_reg(CSR_INITIAL_SKIPS, lead);
      if (pick[3]) put_reg(CSR_SKIP_COUNT, CSR_DATA_W'(gap));
      csr_we <= 1'b0;
   endtask

   function automatic logic [CNT_W-1:0] pick_total();
      case ($urandom_range(9))
         0:       return '0;
         1:       return TOTAL_TOP;
         2:       return CNT_W'($urandom_range(0, 1048576));
         default: return CNT_W'($urandom_range(1, 40));
      endcase
   endfunction

   initial begin
      #10_000_000;
      $display("tb_bit_balance_predictor_unit failed");
      $finish;
   end

   initial begin
      int               counted;
      int               len;
      int               ones_pct;
      logic             cs;
      logic             d;
      logic             fresh;
      logic [CNT_W-1:0]  lead;
      logic [SKIP_W-1:0] gap;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // state runs on from reset with no chunk marker, all totals zero
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b0);

      // two dropped bits, then every other bit, zeros overdrawn
      configure(21'd3, 21'd1, 21'd2, 16'd1, 4'b1111);
      send_bit(1'b1, 1'b1);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b0);

      // widen the period, then shrink it below the current phase mid-chunk
      configure('0, '0, '0, 16'd3, 4'b1000);
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b0);
      configure('0, '0, '0, 16'd1, 4'b1000);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b0);

      configure(TOTAL_TOP, '0, '0, '0, 4'b1111);
      send_bit(1'b1, 1'b1);
      send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b0);

      configure('0, TOTAL_TOP, '0, GAP_TOP, 4'b1111);
      send_bit(1'b0, 1'b1);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b0);

      counted = 0;
      while (counted < ITEMS) begin
         case ($urandom_range(19))
            0:             lead = TOTAL_TOP;
            1:             lead = CNT_W'($urandom_range(7, 40));
            2, 3, 4, 5, 6: lead = CNT_W'($urandom_range(1, 6));
            default:       lead = '0;
         endcase
         case ($urandom_range(19))
            0:             gap = GAP_TOP;
            1, 2:          gap = SKIP_W'($urandom_range(5, 20));
            3, 4, 5, 6, 7: gap = SKIP_W'($urandom_range(1, 4));
            default:       gap = '0;
         endcase
         configure(pick_total(), pick_total(), lead, gap, 4'($urandom_range(1, 15)));

         repeat ($urandom_range(1, 3)) begin
            if (counted >= 1200) begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end else if (counted >= 600) begin
               send_idle_pct = 53;
               recv_idle_pct = 28;
            end
            if ($urandom_range(9) == 0) settle();
            // mostly well-formed chunks; some continue the last one
            fresh    = $urandom_range(99) < 85;
            len      = $urandom_range(1, 60);
            ones_pct = $urandom_range(0, 100);
            for (int k = 0; k < len; k++) begin
               cs = (k == 0 && fresh) || ($urandom_range(99) < 2);
               d  = $urandom_range(99) < ones_pct;
               counted++;
               send_bit(d, cs);
            end
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("tb_bit_balance_predictor_unit passed");
      end else begin
         $display("tb_bit_balance_predictor_unit failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/bbp_pkg.sv
sv/bbp_ctrl.sv
sv/bbp_dp.sv
sv/bit_balance_predictor_unit.sv
tb/bit_balance_checker.sv
tb/tb_bit_balance_predictor_unit.sv
